@@ rtl/tpc_pkg.sv @@
// Shared types and constants for the text pager cursor tracker.
// No dependencies; imported by every module of the block.
package tpc_pkg;

  // Geometry defaults
  localparam int SCREEN_COLS_DEF = 80;
  localparam int TAB_WIDTH_DEF   = 8;
  localparam int COL_W           = 7;
  localparam int LINE_W          = 8;
  localparam logic [LINE_W-1:0] PAGE_LINES_RST = 8'd22;

  // Depth of the front-to-back queue
  localparam int Q_DEPTH = 2;

  // Byte codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UC_N  = 8'h4E;
  localparam logic [7:0] CH_UC_Q  = 8'h51;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_Q  = 8'h71;
  localparam logic [7:0] CH_HIBIT = 8'h80;

  // Request types
  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  // Action codes reported on the result
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_PAGE   = 3'd1;
  localparam logic [2:0] ACT_LINE   = 3'd2;
  localparam logic [2:0] ACT_QUIT   = 3'd3;
  localparam logic [2:0] ACT_REWIND = 3'd4;
  localparam logic [2:0] ACT_SKIP   = 3'd5;

  // Class of a text byte
  typedef enum logic [2:0] {
    CLS_LF,
    CLS_CR,
    CLS_BS,
    CLS_TAB,
    CLS_PRINT
  } txt_cls_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       page_end;
    logic [2:0] action;
    logic       rejected;
  } rsp_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic       is_key;
    txt_cls_t   cls;
    logic [7:0] obyte;
    logic [2:0] act;
  } work_t;

endpackage

@@ rtl/tpc_front.sv @@
// Front decoder: classifies text bytes and key codes.
// Depends on tpc_pkg.
module tpc_front
  import tpc_pkg::*;
(
  input  req_t  req,
  output work_t work
);

  always_comb begin
    work        = '0;
    work.is_key = (req.req_type == REQ_KEY);
    work.obyte  = req.data_byte;
    work.cls    = CLS_PRINT;
    work.act    = ACT_NONE;

    unique case (req.data_byte)
      CH_LF:   work.cls = CLS_LF;
      CH_CR:   work.cls = CLS_CR;
      CH_BS:   work.cls = CLS_BS;
      CH_TAB:  work.cls = CLS_TAB;
      default: begin
        work.cls = CLS_PRINT;
        // control and high-bit bytes are sanitized
        if (req.data_byte < CH_SPACE || (req.data_byte & CH_HIBIT) != 8'd0) begin
          work.obyte = CH_QMARK;
        end
      end
    endcase

    unique case (req.data_byte) inside
      CH_SPACE:         work.act = ACT_PAGE;
      CH_CR, CH_LF:     work.act = ACT_LINE;
      CH_LC_Q, CH_UC_Q: work.act = ACT_QUIT;
      CH_QUOTE:         work.act = ACT_REWIND;
      CH_LC_N, CH_UC_N: work.act = ACT_SKIP;
      default:          work.act = ACT_NONE;
    endcase
  end

endmodule

@@ rtl/tpc_queue.sv @@
// Short queue between the front decoder and the back executor.
// Depends on tpc_pkg for the work item type and depth.
module tpc_queue
  import tpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_item,
  output logic  full,
  input  logic  pop,
  output work_t pop_item,
  output logic  not_empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

  work_t             slot [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue pop while empty");
  assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count out of range");

endmodule

@@ rtl/tpc_back.sv @@
// Back executor: cursor column/line, pause state, page size and result register.
// Depends on tpc_pkg.
module tpc_back
  import tpc_pkg::*;
#(
  parameter int SCREEN_COLS = SCREEN_COLS_DEF,
  parameter int TAB_WIDTH   = TAB_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        q_valid,
  input  work_t       q_item,
  output logic        q_pop,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  localparam int PH_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(SCREEN_COLS - 1);
  localparam logic [PH_W-1:0]   PH_LAST    = PH_W'(TAB_WIDTH - 1);
  localparam logic [PH_W-1:0]   PH_AT_LAST = PH_W'((SCREEN_COLS - 1) % TAB_WIDTH);
  localparam logic [COL_W:0]    COLS_X     = (COL_W + 1)'(SCREEN_COLS);
  localparam logic [COL_W:0]    TAB_X      = (COL_W + 1)'(TAB_WIDTH);
  localparam logic [LINE_W-1:0] LINE_MAX   = '1;

  logic [COL_W-1:0]  col, col_next;
  logic [PH_W-1:0]   phase, phase_next;   // col modulo TAB_WIDTH
  logic [LINE_W-1:0] line, line_next;
  logic              paused, paused_next;
  logic [LINE_W-1:0] page_lines;
  rsp_t              res;

  logic [LINE_W-1:0] line_inc;
  logic              page_full;
  logic [COL_W:0]    tab_col;
  logic [COL_W:0]    prn_col;
  logic              wrap;

  assign q_pop = q_valid && (!rsp_valid || !rsp_stall);

  assign line_inc  = (line == LINE_MAX) ? line : line + 1'b1;
  assign page_full = (line_inc >= page_lines);
  assign tab_col   = {1'b0, col} + TAB_X - (COL_W + 1)'(phase);
  assign prn_col   = {1'b0, col} + 1'b1;

  always_comb begin
    col_next    = col;
    phase_next  = phase;
    line_next   = line;
    paused_next = paused;
    res         = '0;
    wrap        = 1'b0;

    if (!q_item.is_key) begin
      if (paused) begin
        res.rejected = 1'b1;
      end else begin
        res.out_valid = 1'b1;
        res.out_byte  = q_item.obyte;
        case (q_item.cls)
          CLS_LF: begin
            wrap = 1'b1;
          end
          CLS_CR: begin
            col_next   = '0;
            phase_next = '0;
          end
          CLS_BS: begin
            if (col != '0) begin
              col_next   = col - 1'b1;
              phase_next = (phase == '0) ? PH_LAST : phase - 1'b1;
            end else begin
              col_next   = COL_LAST;
              phase_next = PH_AT_LAST;
              line_next  = (line != '0) ? line - 1'b1 : line;
            end
          end
          CLS_TAB: begin
            if (tab_col >= COLS_X) begin
              wrap = 1'b1;
            end else begin
              col_next   = tab_col[COL_W-1:0];
              phase_next = '0;
            end
          end
          default: begin
            if (prn_col >= COLS_X) begin
              wrap = 1'b1;
            end else begin
              col_next   = prn_col[COL_W-1:0];
              phase_next = (phase == PH_LAST) ? '0 : phase + 1'b1;
            end
          end
        endcase
        if (wrap) begin
          col_next   = '0;
          phase_next = '0;
          line_next  = line_inc;
          if (page_full) begin
            paused_next  = 1'b1;
            res.page_end = 1'b1;
          end
        end
      end
    end else if (paused && q_item.act != ACT_NONE) begin
      res.action  = q_item.act;
      paused_next = 1'b0;
      if (q_item.act == ACT_LINE) begin
        line_next = (page_lines != '0) ? page_lines - 1'b1 : '0;
      end else begin
        line_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      phase      <= '0;
      line       <= '0;
      paused     <= 1'b0;
      page_lines <= PAGE_LINES_RST;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_lines <= cfg_data;
      end
      if (q_pop) begin
        col       <= col_next;
        phase     <= phase_next;
        line      <= line_next;
        paused    <= paused_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) col <= COL_LAST)
    else $error("cursor column past last column");
  assert property (@(posedge clk) disable iff (rst) q_pop && res.page_end |=> paused)
    else $error("page end without pause");
  assert property (@(posedge clk) disable iff (rst)
      q_pop && !q_item.is_key && paused |=> rsp.rejected && !rsp.out_valid && $stable(col))
    else $error("text while paused not dropped");
  assert property (@(posedge clk) disable iff (rst) q_pop && res.action != ACT_NONE |=> !paused)
    else $error("key action did not resume");

endmodule

@@ rtl/text_pager_cursor_tracker.sv @@
// Top level of the text pager cursor tracker: front decoder, queue, back executor.
// Depends on tpc_pkg, tpc_front, tpc_queue and tpc_back.
//
//   channel | signals                       | payload        | flow control
//   --------+-------------------------------+----------------+------------------------
//   request | req_valid, req_stall, req     | req_t          | transfer: valid & !stall
//   result  | rsp_valid, rsp_stall, rsp     | rsp_t          | transfer: valid & !stall
//   config  | cfg_valid, cfg_ready, cfg_data| page_lines, 8b | transfer: valid & ready
//
// One item per cycle sustained while the result side does not stall; each request gives
// one result (decode into the queue, then the cursor update into the result register).
// The cursor update is a loop on the column/line/pause registers in the back part.
// Synchronous active-high reset clears the cursor, the pause flag, the queue and
// sets page_lines to 22. The front stalls only when the queue is full; the back
// keeps working while the result register is free or being taken.
module text_pager_cursor_tracker
  import tpc_pkg::*;
#(
  parameter int SCREEN_COLS = SCREEN_COLS_DEF,
  parameter int TAB_WIDTH   = TAB_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  // result channel
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  // page size register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  work_t dec_item;
  work_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  req_xfer;

  // the user must send config writes only while idle, which the block does not enforce; the port is always ready
  assign cfg_ready = 1'b1;

  // a request transfers whenever the queue has room
  assign req_stall = q_full;
  assign req_xfer  = req_valid && !req_stall;

  tpc_front u_front (
    .req  (req),
    .work (dec_item)
  );

  tpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_xfer),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  tpc_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .TAB_WIDTH   (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ tb/text_pager_cursor_tracker_tb.sv @@
// Self-checking testbench for text_pager_cursor_tracker: directed and random text/key traffic.
// Holds its own cursor/pause predictor in a scoreboard class; needs only tpc_pkg and the RTL.
// Drives at the falling edge, samples transfers at the rising edge, random idling on both sides.
module text_pager_cursor_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpc_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RST_CYCLES  = 6;
  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer on any channel
  localparam int DRAIN_TAIL  = 6;     // margin after the last expected result

  // Cursor/pause predictor plus the queue of results it is waiting for.
  class cursor_scoreboard;
    logic [7:0] page_lines;
    logic [6:0] col;
    logic [7:0] line;
    bit         paused;
    rsp_t       pending_rsp[$];
    int         errors;

    function new();
      page_lines = PAGE_LINES_RST;
      col        = '0;
      line       = '0;
      paused     = 1'b0;
      errors     = 0;
    endfunction

    function void set_page_lines(logic [7:0] value);
      page_lines = value;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    // Line advance saturates at 255; pauses once the page is full.
    function bit advance_line();
      if (line != 8'hFF) line = line + 8'd1;
      if (line >= page_lines) begin
        paused = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Note an accepted request: update cursor state, queue the expected result.
    function void note_request(req_t item);
      rsp_t exp_rsp;
      int   next_col;
      exp_rsp = '0;
      if (item.req_type == REQ_TEXT) begin
        if (paused) begin
          exp_rsp.rejected = 1'b1;
        end else begin
          exp_rsp.out_valid = 1'b1;
          exp_rsp.out_byte  = item.data_byte;
          case (item.data_byte)
            CH_LF: begin
              col = '0;
              exp_rsp.page_end = advance_line();
            end
            CH_CR: begin
              col = '0;
            end
            CH_BS: begin
              if (col != 0) begin
                col = col - 7'd1;
              end else begin
                if (line != 0) line = line - 8'd1;
                col = 7'(SCREEN_COLS_DEF - 1);
              end
            end
            CH_TAB: begin
              next_col = (int'(col) / TAB_WIDTH_DEF + 1) * TAB_WIDTH_DEF;
              if (next_col >= SCREEN_COLS_DEF) begin
                col = '0;
                exp_rsp.page_end = advance_line();
              end else begin
                col = 7'(next_col);
              end
            end
            default: begin
              if (item.data_byte < CH_SPACE || (item.data_byte & CH_HIBIT) != 0)
                exp_rsp.out_byte = CH_QMARK;
              next_col = int'(col) + 1;
              if (next_col >= SCREEN_COLS_DEF) begin
                col = '0;
                exp_rsp.page_end = advance_line();
              end else begin
                col = 7'(next_col);
              end
            end
          endcase
        end
      end else if (paused) begin
        case (item.data_byte)
          CH_SPACE:        exp_rsp.action = ACT_PAGE;
          CH_CR, CH_LF:    exp_rsp.action = ACT_LINE;
          CH_LC_Q, CH_UC_Q: exp_rsp.action = ACT_QUIT;
          CH_QUOTE:        exp_rsp.action = ACT_REWIND;
          CH_LC_N, CH_UC_N: exp_rsp.action = ACT_SKIP;
          default:         exp_rsp.action = ACT_NONE;
        endcase
        if (exp_rsp.action == ACT_LINE)
          line = (page_lines != 0) ? page_lines - 8'd1 : 8'd0;
        else if (exp_rsp.action != ACT_NONE)
          line = '0;
        if (exp_rsp.action != ACT_NONE) paused = 1'b0;
      end
      pending_rsp.push_back(exp_rsp);
    endfunction

    function void report(string field, logic [7:0] exp_val, logic [7:0] got_val);
      errors++;
      $display("%0t ERROR %s mismatch: expected 0x%0h actual 0x%0h",
               $time, field, exp_val, got_val);
    endfunction

    // Compare one accepted result with the oldest expectation, field by field.
    function void check_result(rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected result: expected none actual %p", $time, got);
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.out_byte !== exp_rsp.out_byte)   report("out_byte", exp_rsp.out_byte, got.out_byte);
      if (got.out_valid !== exp_rsp.out_valid)
        report("out_valid", 8'(exp_rsp.out_valid), 8'(got.out_valid));
      if (got.page_end !== exp_rsp.page_end)
        report("page_end", 8'(exp_rsp.page_end), 8'(got.page_end));
      if (got.action !== exp_rsp.action)
        report("action", 8'(exp_rsp.action), 8'(got.action));
      if (got.rejected !== exp_rsp.rejected)
        report("rejected", 8'(exp_rsp.rejected), 8'(got.rejected));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_stall;
  rsp_t       rsp;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  cursor_scoreboard sb = new();
  bit idle_en;  // random gaps on both sides while set

  text_pager_cursor_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Transfer monitor: everything is judged at the rising edge, inputs having
  // settled at the previous falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if (req_valid && !req_stall) sb.note_request(req);
      if (cfg_valid && cfg_ready) sb.set_page_lines(cfg_data);
    end
  end

  // Result side back-pressure: random stall bursts while idling is on.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 99) < 15) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no transfer at all.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ERROR timeout: no transfer for %0d cycles", $time, quiet);
    $display("TEST FAILED");
    $finish;
  end

  function automatic req_t make_req(logic kind, logic [7:0] code);
    req_t item;
    item.req_type  = kind;
    item.data_byte = code;
    return item;
  endfunction

  // Next request, shaped by the predicted pause state: mostly text while running,
  // mostly recognized keys while paused, with a share of ignored/rejected traffic.
  function automatic req_t pick_req(int nl_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (sb.paused) begin
      if (roll < 10) return make_req(REQ_TEXT, 8'($urandom_range(0, 255)));
      if (roll < 25) return make_req(REQ_KEY, 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 7))
        0: return make_req(REQ_KEY, CH_SPACE);
        1: return make_req(REQ_KEY, CH_CR);
        2: return make_req(REQ_KEY, CH_LF);
        3: return make_req(REQ_KEY, CH_LC_Q);
        4: return make_req(REQ_KEY, CH_UC_Q);
        5: return make_req(REQ_KEY, CH_QUOTE);
        6: return make_req(REQ_KEY, CH_LC_N);
        default: return make_req(REQ_KEY, CH_UC_N);
      endcase
    end
    if (roll < 5) return make_req(REQ_KEY, 8'($urandom_range(0, 255)));
    roll = $urandom_range(0, 99);
    if (roll < nl_pct)      return make_req(REQ_TEXT, CH_LF);
    if (roll < nl_pct + 4)  return make_req(REQ_TEXT, CH_CR);
    if (roll < nl_pct + 9)  return make_req(REQ_TEXT, CH_BS);
    if (roll < nl_pct + 19) return make_req(REQ_TEXT, CH_TAB);
    if (roll < nl_pct + 34) return make_req(REQ_TEXT, 8'($urandom_range(0, 255)));
    return make_req(REQ_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
  endfunction

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // One request transfer; payload holds until the block takes it.
  task automatic send_req(input req_t item);
    if (idle_en && $urandom_range(0, 99) < 12) idle_gap($urandom_range(1, 6));
    @(negedge clk);
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Page size write, only once every outstanding result has come back.
  task automatic write_page_lines(input logic [7:0] value);
    idle_gap(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] lines, input int count, input int nl_pct,
                           input bit with_idle);
    write_page_lines(lines);
    idle_en = with_idle;
    repeat (count) send_req(pick_req(nl_pct));
  endtask

  initial begin
    req_t directed[$];
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_en   = 1'b1;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sequence with a one-line page so every line advance pauses.
    // Covers sanitizing, tab wrap from the last column, backspace wrap with the
    // line held at zero, text while paused, q while running, every other key while paused.
    directed = '{
      make_req(REQ_TEXT, 8'h41),    make_req(REQ_TEXT, 8'h00),
      make_req(REQ_TEXT, 8'hFF),    make_req(REQ_TEXT, 8'h7F),
      make_req(REQ_TEXT, CH_TAB),   make_req(REQ_TEXT, CH_BS),
      make_req(REQ_TEXT, CH_CR),    make_req(REQ_TEXT, CH_BS),
      make_req(REQ_TEXT, CH_TAB),   make_req(REQ_TEXT, 8'h78),
      make_req(REQ_KEY, 8'h7A),     make_req(REQ_KEY, CH_SPACE),
      make_req(REQ_KEY, CH_LC_Q),   make_req(REQ_TEXT, CH_LF),
      make_req(REQ_KEY, CH_UC_Q),   make_req(REQ_TEXT, CH_LF),
      make_req(REQ_KEY, CH_QUOTE),  make_req(REQ_TEXT, CH_LF),
      make_req(REQ_KEY, CH_LC_N),   make_req(REQ_TEXT, CH_LF),
      make_req(REQ_KEY, CH_UC_N),   make_req(REQ_TEXT, CH_LF),
      make_req(REQ_KEY, CH_CR),     make_req(REQ_TEXT, CH_LF),
      make_req(REQ_KEY, CH_LF)
    };
    write_page_lines(8'd1);
    foreach (directed[i]) send_req(directed[i]);

    // Random phases: short page with long lines (column wrap), full 255-line page
    // driven by newlines, zero page size, reset size, then a burst with no idling.
    run_phase(8'd3, 300, 5, 1'b1);
    run_phase(8'd255, 450, 75, 1'b1);
    run_phase(8'd0, 80, 20, 1'b1);
    run_phase(PAGE_LINES_RST, 300, 12, 1'b1);
    run_phase(8'($urandom_range(1, 40)), 200, 15, 1'b0);

    idle_gap(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t ERROR %0d results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
